@@ design/sirad_pkg.sv @@
// Package for the signed integer to radix digits block.
// Holds character codes, register indexes and shared widths.
// Depends on nothing.
package sirad_pkg;

   typedef logic [7:0] char_type;

   localparam char_type CHAR_PLUS  = 8'h2B;
   localparam char_type CHAR_MINUS = 8'h2D;
   localparam char_type CHAR_NUL   = 8'h00;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int COUNT_WIDTH     = 5;
   localparam int TABLE_BYTES     = 16;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_DIGIT_COUNT = 2'd0;
   localparam csr_index_type CSR_DIGITS_LOW  = 2'd1;
   localparam csr_index_type CSR_DIGITS_HIGH = 2'd2;

endpackage

@@ design/signed_int_to_radix_digits.sv @@
// Top level of the signed integer to radix digits block.
// Converts one signed value per item into character codes in a configured base.
// Depends on sirad_pkg.
//
// A start pulse while busy is low hands over one signed value. The block then
// checks the digit table, one table position per cycle (the check is skipped
// when digit_count is below 2 or above MAX_DIGITS, and a bad entry ends it
// early; in either case the item produces no characters at all). It then
// divides the magnitude by the base with one shared restoring divider that
// handles 8 dividend bits per cycle; each digit divides only the significant
// bytes of the current quotient, so leading zero bytes are skipped. Finally it
// emits a minus sign if the value is negative and the digits most significant
// first, one character per cycle on rsp_strobe, with rsp_last on the final one.
// The receiver cannot stall: each character is shown for exactly one cycle.
// Busy stays high from the accepted item until the final character is being
// presented, or until the item ends without characters, and the next item may start then.
// Configuration writes are always taken and must only be made while idle.
module signed_int_to_radix_digits #(
   parameter int MAX_DIGITS  = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [VALUE_WIDTH-1:0]           req_value,
   output logic                                    rsp_strobe,
   output logic [7:0]                              rsp_char_code,
   output logic                                    rsp_last,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  sirad_pkg::csr_index_type                csr_index,
   input  logic [sirad_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam int IW     = $clog2(MAX_DIGITS);
   localparam int NCHUNK = (VALUE_WIDTH + 7) / 8;
   localparam int DW     = NCHUNK * 8;
   localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PW     = $clog2(VALUE_WIDTH);
   localparam int CNTW   = sirad_pkg::COUNT_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_EMIT
   } state_type;

   state_type                   state_ff;
   logic [CNTW-1:0]             digit_count_ff;
   logic [63:0]                 digits_low_ff;
   logic [63:0]                 digits_high_ff;
   logic [DW-1:0]               mag_ff;
   logic                        neg_ff;
   logic [IW-1:0]               idx_ff;
   logic [IW-1:0]               rem_ff;
   logic [CW-1:0]               chunk_ff;
   logic [PW-1:0]               nd_ff;
   logic [PW-1:0]               ptr_ff;
   logic [IW-1:0]               digit_buf_ff [VALUE_WIDTH];
   logic                        rsp_strobe_ff;
   sirad_pkg::char_type         rsp_char_code_ff;
   logic                        rsp_last_ff;

   sirad_pkg::char_type         tab [MAX_DIGITS];
   logic [127:0]                table_bits;
   logic                        entry_bad;
   logic [IW-1:0]               rem_in;
   logic [7:0]                  qchunk;
   logic [DW-1:0]               quo;
   logic [VALUE_WIDTH-1:0]      mag_in;
   logic [5:0]                  trial;
   logic [5:0]                  base6;

   // Index of the highest nonzero byte, or zero when the word is zero.
   function automatic logic [CW-1:0] top_chunk(input logic [DW-1:0] v);
      logic [CW-1:0] top;
      top = '0;
      for (int c = 0; c < NCHUNK; c++) begin
         if (v[c*8 +: 8] != 8'd0) begin
            top = CW'(c);
         end
      end
      return top;
   endfunction

   assign busy          = (state_ff != S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_char_code = rsp_char_code_ff;
   assign rsp_last      = rsp_last_ff;

   assign table_bits = {digits_high_ff, digits_low_ff};
   always_comb begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
         tab[k] = table_bits[k*8 +: 8];
      end
   end

   // Table check for one position: a forbidden character or a later duplicate.
   always_comb begin
      entry_bad = (tab[idx_ff] == sirad_pkg::CHAR_PLUS) ||
                  (tab[idx_ff] == sirad_pkg::CHAR_MINUS) ||
                  (tab[idx_ff] == sirad_pkg::CHAR_NUL);
      for (int j = 0; j < MAX_DIGITS; j++) begin
         if ((IW'(j) > idx_ff) && (CNTW'(j) < digit_count_ff) && (tab[j] == tab[idx_ff])) begin
            entry_bad = 1'b1;
         end
      end
   end

   // One byte of restoring division by the base. The remainder stays below the
   // base, so it fits the digit index width.
   always_comb begin
      base6  = 6'(digit_count_ff);
      rem_in = rem_ff;
      trial  = '0;
      qchunk = '0;
      for (int b = 7; b >= 0; b--) begin
         trial = {(6 - IW - 1)'(0), rem_in, mag_ff[{chunk_ff, 3'b000} + b]};
         if (trial >= base6) begin
            qchunk[b] = 1'b1;
            rem_in    = IW'(trial - base6);
         end else begin
            qchunk[b] = 1'b0;
            rem_in    = IW'(trial);
         end
      end
      quo = mag_ff;
      quo[{chunk_ff, 3'b000} +: 8] = qchunk;
   end

   // Magnitude of the incoming value; the most negative value wraps to 2^(W-1).
   assign mag_in = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_strobe_ff  <= 1'b0;
         digit_count_ff <= '0;
         digits_low_ff  <= '0;
         digits_high_ff <= '0;
      end else begin
         // A character goes out on every cycle spent in the emit state.
         rsp_strobe_ff <= (state_ff == S_EMIT);

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               sirad_pkg::CSR_DIGIT_COUNT: begin
                  digit_count_ff <= csr_data[CNTW-1:0];
               end
               sirad_pkg::CSR_DIGITS_LOW: begin
                  digits_low_ff <= csr_data;
               end
               sirad_pkg::CSR_DIGITS_HIGH: begin
                  digits_high_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  neg_ff <= req_value[VALUE_WIDTH-1];
                  mag_ff <= DW'(mag_in);
                  idx_ff <= '0;
                  if ((digit_count_ff >= CNTW'(2)) && (digit_count_ff <= CNTW'(MAX_DIGITS))) begin
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_CHECK: begin
               if (entry_bad) begin
                  state_ff <= S_IDLE;
               end else if (idx_ff == IW'(digit_count_ff - CNTW'(1))) begin
                  state_ff <= S_DIV;
                  rem_ff   <= '0;
                  nd_ff    <= '0;
                  chunk_ff <= top_chunk(mag_ff);
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_DIV: begin
               mag_ff <= quo;
               if (chunk_ff == '0) begin
                  // Low byte done: the remainder is the next digit.
                  digit_buf_ff[nd_ff] <= rem_in;
                  nd_ff    <= nd_ff + 1'b1;
                  rem_ff   <= '0;
                  chunk_ff <= top_chunk(quo);
                  if ((quo == '0) || (nd_ff == PW'(VALUE_WIDTH - 1))) begin
                     state_ff <= S_EMIT;
                     ptr_ff   <= nd_ff;
                  end
               end else begin
                  rem_ff   <= rem_in;
                  chunk_ff <= chunk_ff - 1'b1;
               end
            end
            S_EMIT: begin
               if (neg_ff) begin
                  rsp_char_code_ff <= sirad_pkg::CHAR_MINUS;
                  rsp_last_ff      <= 1'b0;
                  neg_ff           <= 1'b0;
               end else begin
                  rsp_char_code_ff <= tab[digit_buf_ff[ptr_ff]];
                  rsp_last_ff      <= (ptr_ff == '0);
                  if (ptr_ff == '0) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ptr_ff <= ptr_ff - 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

@@ tb/signed_int_to_radix_digits_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for signed_int_to_radix_digits: random digit sets and values,
// with every emitted character checked against an internal prediction of the text.
// Depends on sirad_pkg and the signed_int_to_radix_digits block.
module signed_int_to_radix_digits_tb;

   // Cycles with nothing accepted on any channel before the run is declared hung. It
   // must exceed the slowest item, the longest sender gap and the settle pause.
   localparam int HANG_LIMIT    = 4000;
   // Pause before a register write and at the end. An item on a bad digit set emits
   // nothing, yet the block may still be checking the set when the queue drains.
   localparam int SETTLE_CYCLES = 150;
   // Writes to this index hit no register and must change nothing.
   localparam sirad_pkg::csr_index_type CSR_UNUSED = 2'd3;

   // Ways of spoiling a digit set. A good set has no fault.
   typedef enum int {
      DIGITS_OK, DIGITS_TOO_FEW, DIGITS_TOO_MANY, DIGITS_HAVE_PLUS, DIGITS_HAVE_MINUS,
      DIGITS_HAVE_NUL, DIGITS_REPEATED
   } digit_set_fault_type;

   // One emitted character as the receiver sees it.
   typedef struct packed {
      sirad_pkg::char_type code;
      logic                last;
   } glyph_type;

   // Keeps a copy of the registers, works out the text that each accepted value
   // should produce, and compares the characters that come out against it in order.
   class radix_scoreboard;
      glyph_type  pending_glyphs[$];
      logic [4:0] base_reg;
      logic [63:0] low_reg;
      logic [63:0] high_reg;
      int         errors;

      function void write_reg(sirad_pkg::csr_index_type idx, logic [63:0] data);
         case (idx)
            sirad_pkg::CSR_DIGIT_COUNT: base_reg = data[4:0];
            sirad_pkg::CSR_DIGITS_LOW: low_reg = data;
            sirad_pkg::CSR_DIGITS_HIGH: high_reg = data;
            default: ;
         endcase
      endfunction

      function sirad_pkg::char_type digit_at(int idx);
         if (idx < 8)
            return low_reg[8*idx +: 8];
         return high_reg[8*(idx-8) +: 8];
      endfunction

      // A set is usable only with 2 to 16 distinct characters, none of them a sign or NUL.
      function bit digits_usable();
         int n;
         sirad_pkg::char_type c;
         n = int'(base_reg);
         if (n < 2 || n > sirad_pkg::TABLE_BYTES)
            return 0;
         for (int i = 0; i < n; i++) begin
            c = digit_at(i);
            if (c == sirad_pkg::CHAR_PLUS || c == sirad_pkg::CHAR_MINUS ||
                c == sirad_pkg::CHAR_NUL)
               return 0;
            for (int j = i + 1; j < n; j++)
               if (digit_at(j) == c)
                  return 0;
         end
         return 1;
      endfunction

      function void note_value(logic signed [31:0] value);
         logic [31:0] mag;
         logic [31:0] radix;
         bit          negative;
         sirad_pkg::char_type digits[$];
         if (!digits_usable())
            return;
         radix = 32'(base_reg);
         negative = value[31];
         // Negating the most negative value wraps back to 2^31, which is its magnitude.
         mag = negative ? (~value + 32'd1) : value;
         // Least significant digit first; zero still yields one digit.
         do begin
            digits.push_back(digit_at(int'(mag % radix)));
            mag = mag / radix;
         end while (mag != 0);
         if (negative)
            pending_glyphs.push_back(glyph_type'{sirad_pkg::CHAR_MINUS, 1'b0});
         for (int i = digits.size() - 1; i >= 0; i--)
            pending_glyphs.push_back(glyph_type'{digits[i], i == 0});
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t ns: %s", $time, what);
      endtask

      task check_char(sirad_pkg::char_type code, logic last);
         glyph_type want;
         if (pending_glyphs.size() == 0) begin
            report($sformatf("character %02h last %0b with nothing expected", code, last));
            return;
         end
         want = pending_glyphs.pop_front();
         if (want.code !== code)
            report($sformatf("char_code %02h, expected %02h", code, want.code));
         if (want.last !== last)
            report($sformatf("last %0b on char %02h, expected %0b", last, code, want.last));
      endtask

      function int pending();
         return pending_glyphs.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic signed [31:0]      req_value;
   logic                    rsp_strobe;
   logic [7:0]              rsp_char_code;
   logic                    rsp_last;
   logic                    csr_valid;
   logic                    csr_ready;
   sirad_pkg::csr_index_type csr_index;
   logic [sirad_pkg::CSR_DATA_WIDTH-1:0] csr_data;

   radix_scoreboard sb = new();
   int  quiet_cycles;
   bit  moved;
   bit  idling_on;
   int  valid_items;

   signed_int_to_radix_digits dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_char_code(rsp_char_code),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Everything that crosses a channel is seen here, at the rising edge, before the
   // block's own updates of that edge land. Characters are checked before the new item
   // is noted; since expectations are queued in order, either order would do.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         moved = 0;
         if (rsp_strobe) begin
            sb.check_char(rsp_char_code, rsp_last);
            moved = 1;
         end
         if (start && !busy) begin
            sb.note_value(req_value);
            moved = 1;
         end
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_data);
            moved = 1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // A block that stops moving ends the run as a failure.
   initial begin
      while (quiet_cycles < HANG_LIMIT)
         @(posedge clock);
      $display("[signed_int_to_radix_digits] ERROR");
      $finish;
   end

   // Offers one value and holds it until the block takes it. The value is presented
   // at the falling edge and taken at a rising edge where busy is low. Afterwards the
   // sender sometimes goes quiet, briefly or for longer than a whole item, so that
   // start comes back at every point of the block's work.
   task send_value(logic signed [31:0] value);
      int gap;
      @(negedge clock);
      start <= 1;
      req_value <= value;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      if (idling_on && $urandom_range(0, 99) < 14) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            start <= 0;
            req_value <= $urandom;
         end
      end
   endtask

   // Lets the block drain: no item offered, every expected character seen, and then a
   // pause long enough for an item on a bad digit set to finish its checks.
   task settle();
      @(negedge clock);
      start <= 0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_reg(sirad_pkg::csr_index_type idx, logic [63:0] data);
      if (idling_on && $urandom_range(0, 99) < 14)
         repeat ($urandom_range(1, 4)) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      forever begin
         @(posedge clock);
         if (csr_ready)
            break;
      end
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Loads the base and both halves of the digit set. The base is written with junk in
   // the upper data bits, which the register must drop. Now and then the unused index
   // is written too.
   task load_digits(logic [4:0] count, logic [63:0] low_part, logic [63:0] high_part);
      logic [63:0] data;
      data = {$urandom, $urandom};
      data[4:0] = count;
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_UNUSED, {$urandom, $urandom});
      write_reg(sirad_pkg::CSR_DIGIT_COUNT, data);
      write_reg(sirad_pkg::CSR_DIGITS_LOW, low_part);
      write_reg(sirad_pkg::CSR_DIGITS_HIGH, high_part);
   endtask

   // Builds a random digit set with the requested fault. Positions at or past the
   // base get arbitrary bytes, signs and NUL included, since the block must ignore them.
   function automatic void make_digit_set(input digit_set_fault_type fault,
                                          output logic [4:0] count,
                                          output logic [127:0] chars);
      bit          used[256];
      logic [7:0]  c;
      int          n;
      int          i;
      int          j;
      for (i = 0; i < 256; i++)
         used[i] = 0;
      used[sirad_pkg::CHAR_PLUS] = 1;
      used[sirad_pkg::CHAR_MINUS] = 1;
      used[sirad_pkg::CHAR_NUL] = 1;
      for (i = 0; i < sirad_pkg::TABLE_BYTES; i++) begin
         c = 8'($urandom_range(1, 255));
         while (used[c])
            c = 8'($urandom_range(1, 255));
         used[c] = 1;
         chars[8*i +: 8] = c;
      end
      case (fault)
         DIGITS_OK: begin
            // Bases 2 and 16 are the extremes and come up often.
            case ($urandom_range(0, 9))
               0: n = 2;
               1: n = 16;
               default: n = $urandom_range(3, 15);
            endcase
         end
         DIGITS_TOO_FEW: n = $urandom_range(0, 1);
         DIGITS_TOO_MANY: n = $urandom_range(17, 31);
         default: n = $urandom_range(2, 16);
      endcase
      for (i = n; i < sirad_pkg::TABLE_BYTES; i++) begin
         case ($urandom_range(0, 4))
            0: chars[8*i +: 8] = sirad_pkg::CHAR_PLUS;
            1: chars[8*i +: 8] = sirad_pkg::CHAR_MINUS;
            2: chars[8*i +: 8] = sirad_pkg::CHAR_NUL;
            3: chars[8*i +: 8] = chars[7:0];
            default: chars[8*i +: 8] = 8'($urandom_range(0, 255));
         endcase
      end
      if (n >= 2 && n <= sirad_pkg::TABLE_BYTES) begin
         i = $urandom_range(0, n - 1);
         case (fault)
            DIGITS_HAVE_PLUS: chars[8*i +: 8] = sirad_pkg::CHAR_PLUS;
            DIGITS_HAVE_MINUS: chars[8*i +: 8] = sirad_pkg::CHAR_MINUS;
            DIGITS_HAVE_NUL: chars[8*i +: 8] = sirad_pkg::CHAR_NUL;
            DIGITS_REPEATED: begin
               j = $urandom_range(0, n - 2);
               if (j >= i)
                  j++;
               chars[8*j +: 8] = chars[8*i +: 8];
            end
            default: ;
         endcase
      end
      count = 5'(n);
   endfunction

   // Mostly full-width random values, with small magnitudes for short runs of text and
   // the edges of the range now and then.
   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] value;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: value = 32'sh8000_0000;
               1: value = 32'sh7FFF_FFFF;
               2: value = 0;
               3: value = -1;
               default: value = 1;
            endcase
         end
         1, 2, 3: begin
            value = $urandom_range(0, 1000);
            if ($urandom_range(0, 1))
               value = -value;
         end
         default: value = $urandom;
      endcase
      return value;
   endfunction

   initial begin
      digit_set_fault_type fault;
      logic [4:0]       count;
      logic [127:0]     chars;
      int               phase;
      int               quota;

      reset = 1;
      start = 0;
      req_value = 0;
      csr_valid = 0;
      csr_index = sirad_pkg::CSR_DIGIT_COUNT;
      csr_data = 0;
      idling_on = 1;
      valid_items = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Out of reset the base is zero, so these items must produce no text at all.
      send_value(0);
      send_value(-1);
      settle();

      // Decimal. The unused upper bytes hold signs and NUL, which must not matter.
      load_digits(5'd10, 64'h3736_3534_3332_3130, 64'h002B_2D00_2D2B_3938);
      send_value(0);
      send_value(1);
      send_value(-1);
      send_value(10);
      send_value(-10);
      send_value(32'sh7FFF_FFFF);
      send_value(32'sh8000_0000);
      settle();

      // Binary gives the longest text: the most negative value is a sign and 32 digits.
      load_digits(5'd2, 64'h2B2D_00FF_EE2D_3130, 64'hFFFF_FFFF_FFFF_FFFF);
      send_value(32'sh8000_0000);
      send_value(32'sh7FFF_FFFF);
      send_value(-1);
      settle();

      // Hexadecimal, all sixteen positions in use.
      load_digits(5'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
      send_value(32'sh89AB_CDEF);
      send_value(32'sh7654_3210);
      settle();

      // One item on each kind of bad digit set.
      for (int f = DIGITS_TOO_FEW; f <= DIGITS_REPEATED; f++) begin
         make_digit_set(digit_set_fault_type'(f), count, chars);
         load_digits(count, chars[63:0], chars[127:64]);
         send_value(pick_value());
         settle();
      end

      // Random phases, each with a fresh digit set. Two early phases run with no idling
      // on either side so that back-to-back items get a long stretch.
      phase = 0;
      while (valid_items < 460) begin
         idling_on = !(phase == 2 || phase == 3);
         fault = ($urandom_range(0, 99) < 15) ? digit_set_fault_type'($urandom_range(1, 6))
                                               : DIGITS_OK;
         make_digit_set(fault, count, chars);
         load_digits(count, chars[63:0], chars[127:64]);
         quota = (fault == DIGITS_OK) ? $urandom_range(20, 45) : $urandom_range(3, 6);
         repeat (quota) begin
            send_value(pick_value());
            if (fault == DIGITS_OK)
               valid_items++;
         end
         settle();
         phase++;
      end

      if (sb.errors == 0 && sb.pending() == 0)
         $display("[signed_int_to_radix_digits] OK");
      else
         $display("[signed_int_to_radix_digits] ERROR");
      $finish;
   end

endmodule
